FILE: sv/ir_pulse_distance_frame_decoder_macros.svh
// assertion macros used by the ir pulse-distance frame decoder rtl
`ifndef IR_PULSE_DISTANCE_FRAME_DECODER_MACROS_SVH
`define IR_PULSE_DISTANCE_FRAME_DECODER_MACROS_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define IPDFD_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off while rst_n is low
`define IPDFD_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: sv/ipdfd_pkg.sv
// shared types, constants and helper functions of the ir pulse-distance frame decoder
`timescale 1ns / 1ps
package ipdfd_pkg;

    // field and register widths
    localparam int DUR_W      = 16;
    localparam int TOL_W      = 6;
    localparam int EXC_W      = 8;
    localparam int PSEQ_W     = 8;
    localparam int CFG_DATA_W = 8;
    localparam int CFG_ADDR_W = 2;
    localparam int WORD_CNT_W = 8;
    localparam int KIND_W     = 2;
    localparam int ERR_W      = 3;

    // default parameter values
    localparam int DEF_WORD_BITS   = 32;
    localparam int DEF_SEQ_BITS    = 8;
    localparam int DEF_MAX_ENTRIES = 528;

    // register reset values
    localparam logic [TOL_W-1:0]  TOL_RESET  = 6'd25;
    localparam logic [EXC_W-1:0]  EXC_RESET  = 8'd100;
    localparam logic [PSEQ_W-1:0] PSEQ_RESET = 8'd0;

    // window arithmetic
    localparam int NOM_W     = 13;
    localparam int WIN_W     = 13;
    localparam int FAC_W     = 8;
    localparam int PROD_W    = 21;
    localparam int RECIP_W   = 21;
    localparam int DIV_SHIFT = 27;
    localparam int NUM_WIN   = 7;
    localparam int STEP_W    = 4;
    localparam int NUM_STEPS = 2 * NUM_WIN;

    localparam logic [FAC_W-1:0]   PCT_FULL  = 8'd100;
    // ceil(2^27 / 100), exact floor division for products below 2^20
    localparam logic [RECIP_W-1:0] RECIP_100 = 21'd1342178;

    // nominal durations in microseconds
    localparam logic [NOM_W-1:0] HDR_US        = 13'd4500;
    localparam logic [NOM_W-1:0] BIT_MARK_US   = 13'd579;
    localparam logic [NOM_W-1:0] ONE_SPACE_US  = 13'd1684;
    localparam logic [NOM_W-1:0] ZERO_SPACE_US = 13'd579;
    localparam logic [NOM_W-1:0] TRL_US        = 13'd3000;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_TOL      = 2'd0,
        CFG_EXCESS   = 2'd1,
        CFG_PREV_SEQ = 2'd2
    } cfg_idx_t;

    typedef enum logic [2:0] {
        PH_IDLE      = 3'd0,
        PH_HDR_MARK  = 3'd1,
        PH_HDR_SPACE = 3'd2,
        PH_SEQ       = 3'd3,
        PH_BITS      = 3'd4,
        PH_TRL_SPACE = 3'd5
    } phase_t;

    typedef enum logic [KIND_W-1:0] {
        KIND_SEQ  = 2'd0,
        KIND_WORD = 2'd1,
        KIND_DONE = 2'd2,
        KIND_ERR  = 2'd3
    } kind_t;

    typedef enum logic [ERR_W-1:0] {
        ERR_HDR_MARK  = 3'd0,
        ERR_HDR_SPACE = 3'd1,
        ERR_BIT_MARK  = 3'd2,
        ERR_BIT_SPACE = 3'd3,
        ERR_STALE_SEQ = 3'd4,
        ERR_TRAILER   = 3'd5,
        ERR_OVERLONG  = 3'd6
    } err_t;

    typedef enum logic [2:0] {
        W_HDR_MARK   = 3'd0,
        W_HDR_SPACE  = 3'd1,
        W_BIT_MARK   = 3'd2,
        W_TRL_MARK   = 3'd3,
        W_TRL_SPACE  = 3'd4,
        W_ONE_SPACE  = 3'd5,
        W_ZERO_SPACE = 3'd6
    } win_id_t;

    typedef struct packed {
        logic [WIN_W-1:0] lo;
        logic [WIN_W-1:0] hi;
    } win_t;

    typedef struct packed {
        logic [DUR_W-1:0] duration_us;
        logic             frame_start;
    } item_t;

    function automatic logic [NOM_W-1:0] win_nominal(input win_id_t id);
        logic [NOM_W-1:0] nom;
        case (id)
            W_HDR_MARK, W_HDR_SPACE:   nom = HDR_US;
            W_BIT_MARK:                nom = BIT_MARK_US;
            W_TRL_MARK, W_TRL_SPACE:   nom = TRL_US;
            W_ONE_SPACE:               nom = ONE_SPACE_US;
            W_ZERO_SPACE:              nom = ZERO_SPACE_US;
            default:                   nom = HDR_US;
        endcase
        return nom;
    endfunction

    function automatic logic win_is_mark(input win_id_t id);
        logic mark;
        case (id)
            W_HDR_MARK, W_BIT_MARK, W_TRL_MARK: mark = 1'b1;
            default:                            mark = 1'b0;
        endcase
        return mark;
    endfunction

    // inclusive window test
    function automatic logic in_win(input logic [DUR_W-1:0] d, input win_t w);
        return (d >= DUR_W'(w.lo)) && (d <= DUR_W'(w.hi));
    endfunction

endpackage

FILE: sv/ir_pulse_distance_frame_decoder.sv
// top level of the ir pulse-distance frame decoder: config registers, input register, core
//
//  channel  | handshake              | payload
//  ---------+------------------------+-----------------------------------------------
//  in       | in_valid / in_ready    | duration_us, frame_start
//  out      | out_valid / out_ready  | kind, seq_value, duplicate, word_value,
//           |                        | word_index, error_code
//  cfg      | cfg_we (no wait)       | cfg_addr, cfg_data
//
//  one duration per cycle sustained while results are taken; a result is registered first in the
//  input register, then in the core's result register
//  after reset, and after a write of tolerance_pct or mark_excess_us, in_ready stays low
//  while the window unit walks its 14 bounds through its two multiply stages
//  a held result stalls input only when the input register is also full
`timescale 1ns / 1ps
module ir_pulse_distance_frame_decoder import ipdfd_pkg::*;
#(
    parameter int WORD_BITS   = DEF_WORD_BITS,
    parameter int SEQ_BITS    = DEF_SEQ_BITS,
    parameter int MAX_ENTRIES = DEF_MAX_ENTRIES
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    // input channel
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [DUR_W-1:0]       duration_us,
    input  logic                   frame_start,
    // result channel
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [KIND_W-1:0]      kind,
    output logic [SEQ_BITS-1:0]    seq_value,
    output logic                   duplicate,
    output logic [WORD_BITS-1:0]   word_value,
    output logic [WORD_CNT_W-1:0]  word_index,
    output logic [ERR_W-1:0]       error_code,
    // configuration write port
    input  logic                   cfg_we,
    input  logic [CFG_ADDR_W-1:0]  cfg_addr,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    // configuration registers
    logic [TOL_W-1:0]    tol_reg, tol_next;
    logic [EXC_W-1:0]    excess_reg, excess_next;
    logic [PSEQ_W-1:0]   prev_seq_reg, prev_seq_next;
    logic                retune;

    // input register
    logic                s1_valid_reg, s1_valid_next;
    item_t               s1_item_reg;
    logic                in_xfer;

    // links to the submodules
    win_t [NUM_WIN-1:0]  wins;
    logic                win_ready;
    logic                slot_free;

    // register writes; index 3 lands nowhere
    always_comb
    begin
        tol_next      = tol_reg;
        excess_next   = excess_reg;
        prev_seq_next = prev_seq_reg;
        if (cfg_we)
        begin
            case (cfg_idx_t'(cfg_addr))
                CFG_TOL:      tol_next      = cfg_data[TOL_W-1:0];
                CFG_EXCESS:   excess_next   = cfg_data[EXC_W-1:0];
                CFG_PREV_SEQ: prev_seq_next = cfg_data[PSEQ_W-1:0];
                default:      tol_next      = tol_reg;
            endcase
        end
    end

    // only the window inputs force a recompute
    assign retune = cfg_we && ((cfg_idx_t'(cfg_addr) == CFG_TOL) ||
                               (cfg_idx_t'(cfg_addr) == CFG_EXCESS));

    // the input register frees up when the core consumes it this cycle
    assign in_ready = win_ready && (!s1_valid_reg || slot_free);
    assign in_xfer  = in_valid && in_ready;

    always_comb
    begin
        if (in_xfer)
            s1_valid_next = 1'b1;
        else if (slot_free)
            s1_valid_next = 1'b0;
        else
            s1_valid_next = s1_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tol_reg      <= TOL_RESET;
            excess_reg   <= EXC_RESET;
            prev_seq_reg <= PSEQ_RESET;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            tol_reg      <= tol_next;
            excess_reg   <= excess_next;
            prev_seq_reg <= prev_seq_next;
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            s1_item_reg.duration_us <= duration_us;
            s1_item_reg.frame_start <= frame_start;
        end
    end

    // window bounds from tolerance and mark excess
    ipdfd_win_calc u_win_calc (
        .clk            (clk),
        .rst_n          (rst_n),
        .restart        (retune),
        .tolerance_pct  (tol_reg),
        .mark_excess_us (excess_reg),
        .wins           (wins),
        .ready          (win_ready)
    );

    // per-entry decode and result register
    ipdfd_frame_core #(
        .WORD_BITS   (WORD_BITS),
        .SEQ_BITS    (SEQ_BITS),
        .MAX_ENTRIES (MAX_ENTRIES)
    ) u_frame_core (
        .clk             (clk),
        .rst_n           (rst_n),
        .item_valid      (s1_valid_reg),
        .item            (s1_item_reg),
        .slot_free       (slot_free),
        .wins            (wins),
        .prev_seq_number (prev_seq_reg),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .kind            (kind),
        .seq_value       (seq_value),
        .duplicate       (duplicate),
        .word_value      (word_value),
        .word_index      (word_index),
        .error_code      (error_code)
    );

endmodule

FILE: sv/ipdfd_win_calc.sv
// duration window bounds, recomputed by a short multiply sequence after reset or a retune
`timescale 1ns / 1ps
module ipdfd_win_calc import ipdfd_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 restart,
    input  logic [TOL_W-1:0]     tolerance_pct,
    input  logic [EXC_W-1:0]     mark_excess_us,
    output win_t [NUM_WIN-1:0]   wins,
    output logic                 ready
);

    logic                        busy_reg, busy_next;
    logic [STEP_W-1:0]           step_reg, step_next;
    logic                        prod_valid_reg, prod_valid_next;
    win_id_t                     prod_idx_reg, prod_idx_next;
    logic                        prod_hi_reg, prod_hi_next;
    logic [PROD_W-1:0]           prod_reg, prod_next;
    win_t [NUM_WIN-1:0]          wins_reg, wins_next;

    win_id_t                     step_id;
    logic [NOM_W-1:0]            nom;
    logic [NOM_W-1:0]            base;
    logic [FAC_W-1:0]            factor;
    logic [PROD_W+RECIP_W-1:0]   scaled;
    logic [WIN_W-1:0]            quot;

    // stage one: base times percent factor
    always_comb
    begin
        step_id = win_id_t'(step_reg[STEP_W-1:1]);
        nom     = win_nominal(step_id);
        base    = win_is_mark(step_id) ? nom + NOM_W'(mark_excess_us)
                                       : nom - NOM_W'(mark_excess_us);
        factor  = step_reg[0] ? PCT_FULL + FAC_W'(tolerance_pct)
                              : PCT_FULL - FAC_W'(tolerance_pct);
        prod_next     = PROD_W'(base) * PROD_W'(factor);
        prod_idx_next = step_id;
        prod_hi_next  = step_reg[0];
    end

    // sweep over all bounds
    always_comb
    begin
        busy_next       = busy_reg;
        step_next       = step_reg;
        prod_valid_next = busy_reg;
        if (busy_reg)
        begin
            step_next = step_reg + STEP_W'(1);
            if (step_reg == STEP_W'(NUM_STEPS - 1))
            begin
                busy_next = 1'b0;
                step_next = '0;
            end
        end
        if (restart)
        begin
            busy_next = 1'b1;
            step_next = '0;
        end
    end

    // stage two: divide by 100 through the reciprocal
    always_comb
    begin
        scaled    = (PROD_W + RECIP_W)'(prod_reg) * (PROD_W + RECIP_W)'(RECIP_100);
        quot      = WIN_W'(scaled >> DIV_SHIFT);
        wins_next = wins_reg;
        if (prod_valid_reg)
        begin
            if (prod_hi_reg)
                wins_next[prod_idx_reg].hi = quot + WIN_W'(1);
            else
                wins_next[prod_idx_reg].lo = quot;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg       <= 1'b1;
            step_reg       <= '0;
            prod_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg       <= busy_next;
            step_reg       <= step_next;
            prod_valid_reg <= prod_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg     <= prod_next;
        prod_idx_reg <= prod_idx_next;
        prod_hi_reg  <= prod_hi_next;
        wins_reg     <= wins_next;
    end

    assign wins  = wins_reg;
    assign ready = !busy_reg && !prod_valid_reg;

endmodule

FILE: sv/ipdfd_frame_core.sv
// frame state machine, bit assembly and result register
`include "ir_pulse_distance_frame_decoder_macros.svh"
`timescale 1ns / 1ps
module ipdfd_frame_core import ipdfd_pkg::*;
#(
    parameter int WORD_BITS   = DEF_WORD_BITS,
    parameter int SEQ_BITS    = DEF_SEQ_BITS,
    parameter int MAX_ENTRIES = DEF_MAX_ENTRIES
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   item_valid,
    input  item_t                  item,
    output logic                   slot_free,
    input  win_t [NUM_WIN-1:0]     wins,
    input  logic [PSEQ_W-1:0]      prev_seq_number,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [KIND_W-1:0]      kind,
    output logic [SEQ_BITS-1:0]    seq_value,
    output logic                   duplicate,
    output logic [WORD_BITS-1:0]   word_value,
    output logic [WORD_CNT_W-1:0]  word_index,
    output logic [ERR_W-1:0]       error_code
);

    localparam int MAX_BITS = (WORD_BITS > SEQ_BITS) ? WORD_BITS : SEQ_BITS;
    localparam int CNT_W    = $clog2(MAX_BITS + 1);
    localparam int ENT_W    = $clog2(MAX_ENTRIES + 1);

    phase_t                  phase_reg, phase_next;
    logic [ENT_W-1:0]        entry_count_reg, entry_count_next;
    logic                    expect_mark_reg, expect_mark_next;
    logic [SEQ_BITS-1:0]     seq_shift_reg, seq_shift_next;
    logic [WORD_BITS-1:0]    word_shift_reg, word_shift_next;
    logic [CNT_W-1:0]        bit_count_reg, bit_count_next;
    logic [WORD_CNT_W-1:0]   word_count_reg, word_count_next;

    logic                    out_valid_reg, out_valid_next;
    kind_t                   kind_reg, res_kind;
    logic [SEQ_BITS-1:0]     seq_value_reg, res_seq;
    logic                    duplicate_reg, res_dup;
    logic [WORD_BITS-1:0]    word_value_reg, res_word;
    logic [WORD_CNT_W-1:0]   word_index_reg, res_idx;
    err_t                    error_code_reg, res_err;
    logic                    res_valid;

    logic                    take;
    logic                    active;
    logic                    overlong;
    logic                    hit_hdr_mark, hit_hdr_space, hit_bit_mark;
    logic                    hit_trl_mark, hit_trl_space, hit_one, hit_zero;
    logic                    trl_hit;
    logic [CNT_W-1:0]        cnt_inc;
    logic                    seq_full, word_full;
    logic [SEQ_BITS-1:0]     seq_val;
    logic [WORD_BITS-1:0]    word_val;
    logic                    stale;
    logic                    fail;
    err_t                    fail_code;
    logic                    do_clear;

    assign slot_free = !out_valid_reg || out_ready;
    assign take      = item_valid && slot_free;
    assign active    = (phase_reg != PH_IDLE);
    assign overlong  = (entry_count_reg >= ENT_W'(MAX_ENTRIES));

    assign hit_hdr_mark  = in_win(item.duration_us, wins[W_HDR_MARK]);
    assign hit_hdr_space = in_win(item.duration_us, wins[W_HDR_SPACE]);
    assign hit_bit_mark  = in_win(item.duration_us, wins[W_BIT_MARK]);
    assign hit_trl_mark  = in_win(item.duration_us, wins[W_TRL_MARK]);
    assign hit_trl_space = in_win(item.duration_us, wins[W_TRL_SPACE]);
    assign hit_one       = in_win(item.duration_us, wins[W_ONE_SPACE]);
    assign hit_zero      = in_win(item.duration_us, wins[W_ZERO_SPACE]);

    // trailer mark is tried ahead of a bit mark in the payload
    assign trl_hit   = (phase_reg == PH_BITS) && expect_mark_reg && hit_trl_mark;
    assign cnt_inc   = bit_count_reg + CNT_W'(1);
    assign seq_full  = (cnt_inc >= CNT_W'(SEQ_BITS));
    assign word_full = (cnt_inc >= CNT_W'(WORD_BITS));
    // one wins when both space windows match
    assign seq_val   = seq_shift_reg | (SEQ_BITS'(hit_one) << bit_count_reg);
    assign word_val  = word_shift_reg | (WORD_BITS'(hit_one) << bit_count_reg);
    assign stale     = (PSEQ_W'(seq_val) < prev_seq_number);

    // error detection
    always_comb
    begin
        fail      = 1'b0;
        fail_code = ERR_HDR_MARK;
        if (take && !item.frame_start && active)
        begin
            if (overlong)
            begin
                fail      = 1'b1;
                fail_code = ERR_OVERLONG;
            end
            else
            begin
                case (phase_reg)
                    PH_HDR_MARK:
                    begin
                        fail      = !hit_hdr_mark;
                        fail_code = ERR_HDR_MARK;
                    end
                    PH_HDR_SPACE:
                    begin
                        fail      = !hit_hdr_space;
                        fail_code = ERR_HDR_SPACE;
                    end
                    PH_TRL_SPACE:
                    begin
                        fail      = !hit_trl_space;
                        fail_code = ERR_TRAILER;
                    end
                    PH_SEQ, PH_BITS:
                    begin
                        if (expect_mark_reg)
                        begin
                            fail      = !trl_hit && !hit_bit_mark;
                            fail_code = ERR_BIT_MARK;
                        end
                        else if (!hit_one && !hit_zero)
                        begin
                            fail      = 1'b1;
                            fail_code = ERR_BIT_SPACE;
                        end
                        else if ((phase_reg == PH_SEQ) && seq_full && stale)
                        begin
                            fail      = 1'b1;
                            fail_code = ERR_STALE_SEQ;
                        end
                    end
                    default:
                    begin
                        fail      = 1'b0;
                        fail_code = ERR_HDR_MARK;
                    end
                endcase
            end
        end
    end

    // next phase
    always_comb
    begin
        phase_next = phase_reg;
        if (take)
        begin
            if (item.frame_start)
                phase_next = PH_HDR_MARK;
            else if (fail)
                phase_next = PH_IDLE;
            else
            begin
                case (phase_reg)
                    PH_HDR_MARK:  phase_next = PH_HDR_SPACE;
                    PH_HDR_SPACE: phase_next = PH_SEQ;
                    PH_SEQ:
                    begin
                        if (!expect_mark_reg && seq_full)
                            phase_next = PH_BITS;
                    end
                    PH_BITS:
                    begin
                        if (trl_hit)
                            phase_next = PH_TRL_SPACE;
                    end
                    PH_TRL_SPACE: phase_next = PH_IDLE;
                    default:      phase_next = PH_IDLE;
                endcase
            end
        end
    end

    // frame data path and result
    always_comb
    begin
        entry_count_next = entry_count_reg;
        expect_mark_next = expect_mark_reg;
        seq_shift_next   = seq_shift_reg;
        word_shift_next  = word_shift_reg;
        bit_count_next   = bit_count_reg;
        word_count_next  = word_count_reg;
        do_clear         = 1'b0;
        res_valid        = 1'b0;
        res_kind         = KIND_SEQ;
        res_seq          = '0;
        res_dup          = 1'b0;
        res_word         = '0;
        res_idx          = '0;
        res_err          = ERR_HDR_MARK;
        if (take)
        begin
            if (item.frame_start)
                do_clear = 1'b1;
            else if (fail)
            begin
                do_clear  = 1'b1;
                res_valid = 1'b1;
                res_kind  = KIND_ERR;
                res_err   = fail_code;
                if (fail_code == ERR_STALE_SEQ)
                    res_seq = seq_val;
            end
            else if (active)
            begin
                entry_count_next = entry_count_reg + ENT_W'(1);
                case (phase_reg)
                    PH_HDR_SPACE:
                    begin
                        expect_mark_next = 1'b1;
                        bit_count_next   = '0;
                        seq_shift_next   = '0;
                    end
                    PH_TRL_SPACE:
                    begin
                        do_clear  = 1'b1;
                        res_valid = 1'b1;
                        res_kind  = KIND_DONE;
                        res_idx   = word_count_reg;
                    end
                    PH_SEQ:
                    begin
                        if (expect_mark_reg)
                            expect_mark_next = 1'b0;
                        else
                        begin
                            expect_mark_next = 1'b1;
                            seq_shift_next   = seq_val;
                            bit_count_next   = cnt_inc;
                            if (seq_full)
                            begin
                                bit_count_next  = '0;
                                word_shift_next = '0;
                                res_valid       = 1'b1;
                                res_kind        = KIND_SEQ;
                                res_seq         = seq_val;
                                res_dup         = (PSEQ_W'(seq_val) == prev_seq_number);
                            end
                        end
                    end
                    PH_BITS:
                    begin
                        if (expect_mark_reg)
                        begin
                            if (!trl_hit)
                                expect_mark_next = 1'b0;
                        end
                        else
                        begin
                            expect_mark_next = 1'b1;
                            word_shift_next  = word_val;
                            bit_count_next   = cnt_inc;
                            if (word_full)
                            begin
                                word_count_next = word_count_reg + WORD_CNT_W'(1);
                                word_shift_next = '0;
                                bit_count_next  = '0;
                                res_valid       = 1'b1;
                                res_kind        = KIND_WORD;
                                res_word        = word_val;
                                res_idx         = word_count_reg;
                            end
                        end
                    end
                    default:
                    begin
                        expect_mark_next = expect_mark_reg;
                    end
                endcase
            end
        end
        if (do_clear)
        begin
            entry_count_next = item.frame_start ? ENT_W'(1) : '0;
            expect_mark_next = 1'b1;
            seq_shift_next   = '0;
            word_shift_next  = '0;
            bit_count_next   = '0;
            word_count_next  = '0;
        end
    end

    // result register: loads on a processed item, drains on a transfer
    always_comb
    begin
        if (take)
            out_valid_next = res_valid;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_IDLE;
            entry_count_reg <= '0;
            expect_mark_reg <= 1'b1;
            seq_shift_reg   <= '0;
            word_shift_reg  <= '0;
            bit_count_reg   <= '0;
            word_count_reg  <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            phase_reg       <= phase_next;
            entry_count_reg <= entry_count_next;
            expect_mark_reg <= expect_mark_next;
            seq_shift_reg   <= seq_shift_next;
            word_shift_reg  <= word_shift_next;
            bit_count_reg   <= bit_count_next;
            word_count_reg  <= word_count_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take && res_valid)
        begin
            kind_reg       <= res_kind;
            seq_value_reg  <= res_seq;
            duplicate_reg  <= res_dup;
            word_value_reg <= res_word;
            word_index_reg <= res_idx;
            error_code_reg <= res_err;
        end
    end

    assign out_valid  = out_valid_reg;
    assign kind       = kind_reg;
    assign seq_value  = seq_value_reg;
    assign duplicate  = duplicate_reg;
    assign word_value = word_value_reg;
    assign word_index = word_index_reg;
    assign error_code = error_code_reg;

    `IPDFD_ASSERT_IMP(ast_idle_clean, phase_reg == PH_IDLE, entry_count_reg == '0 && bit_count_reg == '0 && word_count_reg == '0 && expect_mark_reg, "idle with frame state left over")
    `IPDFD_ASSERT_IMP(ast_seq_count, phase_reg == PH_SEQ, bit_count_reg < CNT_W'(SEQ_BITS), "sequence bit count out of range")
    `IPDFD_ASSERT_IMP(ast_word_count, phase_reg == PH_BITS, bit_count_reg < CNT_W'(WORD_BITS), "payload bit count out of range")
    `IPDFD_ASSERT_NXT(ast_start_arms, take && item.frame_start, phase_reg == PH_HDR_MARK && entry_count_reg == ENT_W'(1), "frame start did not arm header")
    `IPDFD_ASSERT_NXT(ast_fail_idle, take && fail, phase_reg == PH_IDLE && out_valid_reg && kind_reg == KIND_ERR, "error did not report and return to idle")

endmodule
